// ===== hw/rtl/dwsm_pkg.sv =====
package dwsm_pkg;

   // Handler states, in the encoding shown on the result channel.
   typedef enum logic [2:0] {
      ST_UNDEF      = 3'd0,
      ST_ENABLED    = 3'd1,
      ST_QUEUED     = 3'd2,
      ST_SIGNALLED  = 3'd3,
      ST_RUN_DIS    = 3'd4,
      ST_QUEUED_DIS = 3'd5,
      ST_DISABLED   = 3'd6,
      ST_RUNNING    = 3'd7
   } state_type;

   // Event codes carried in the func field.
   localparam logic [2:0] EV_INIT    = 3'd0;
   localparam logic [2:0] EV_ENABLE  = 3'd1;
   localparam logic [2:0] EV_DISABLE = 3'd2;
   localparam logic [2:0] EV_SIGNAL  = 3'd3;
   localparam logic [2:0] EV_START   = 3'd4;
   localparam logic [2:0] EV_END     = 3'd5;

   localparam int PctWidth   = 7;
   localparam int WdWidth    = 32;
   localparam int CntWidth   = 16;
   localparam int ScaleWidth = WdWidth + 8;

   localparam logic [PctWidth-1:0]   ThreshReset = 7'd50;
   localparam logic [ScaleWidth-1:0] PctScale   = 40'd100;

   typedef struct packed {
      logic [2:0]         func;
      logic               queue_accepted;
      logic               watchdog_valid;
      logic [WdWidth-1:0] watchdog_remaining;
      logic [WdWidth-1:0] watchdog_limit;
   } req_type;

   typedef struct packed {
      logic [2:0]          new_state;
      logic [2:0]          prev_state;
      logic                queue_request;
      logic                use_threaded;
      logic                run_handler;
      logic                ref_take;
      logic                ref_drop;
      logic                invalid_event;
      logic [CntWidth-1:0] threaded_total;
   } rsp_type;

endpackage

// ===== hw/rtl/dwsm_ctrl.sv =====
module dwsm_ctrl import dwsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  req_type             item,
   input  logic [PctWidth-1:0] thresh_pct,
   output rsp_type             result
);

   state_type           state_ff, state_in;
   logic                ref_ff, ref_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   logic [ScaleWidth-1:0] limit_prod;
   logic [ScaleWidth-1:0] remain_scaled;
   logic                  thr_ok;

   logic qreq, run, take, set_dis, bad, thr, drop;

   // remaining < floor(limit * pct / 100) holds exactly when
   // 100 * (remaining + 1) <= limit * pct, so no divider is needed.
   always_comb begin
      limit_prod    = ScaleWidth'(item.watchdog_limit) * ScaleWidth'(thresh_pct);
      remain_scaled = (ScaleWidth'(item.watchdog_remaining) + ScaleWidth'(1)) * PctScale;
      thr_ok        = item.watchdog_valid && (remain_scaled <= limit_prod);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (item.func)
         EV_INIT: begin
            if (state_ff == ST_UNDEF) state_in = ST_DISABLED;
         end
         EV_ENABLE: begin
            if (state_ff == ST_DISABLED) state_in = ST_ENABLED;
         end
         EV_DISABLE: begin
            case (state_ff)
               ST_DISABLED, ST_ENABLED: state_in = ST_DISABLED;
               ST_RUNNING, ST_SIGNALLED: state_in = ST_RUN_DIS;
               ST_QUEUED: state_in = ST_QUEUED_DIS;
               default: state_in = state_ff;
            endcase
         end
         EV_SIGNAL: begin
            case (state_ff)
               ST_ENABLED: state_in = item.queue_accepted ? ST_QUEUED : ST_SIGNALLED;
               ST_RUNNING: state_in = ST_SIGNALLED;
               default: state_in = state_ff;
            endcase
         end
         EV_START: begin
            case (state_ff)
               ST_QUEUED: state_in = ST_RUNNING;
               ST_QUEUED_DIS: state_in = ST_DISABLED;
               default: state_in = state_ff;
            endcase
         end
         EV_END: begin
            case (state_ff)
               ST_SIGNALLED: state_in = item.queue_accepted ? ST_QUEUED : ST_SIGNALLED;
               ST_RUNNING: state_in = ST_ENABLED;
               ST_RUN_DIS: state_in = ST_DISABLED;
               default: state_in = state_ff;
            endcase
         end
         default: state_in = state_ff;
      endcase
   end

   // Actions and flags.
   always_comb begin
      qreq    = 1'b0;
      run     = 1'b0;
      take    = 1'b0;
      set_dis = 1'b0;
      bad     = 1'b0;
      case (item.func)
         EV_INIT: begin
            bad = (state_ff != ST_UNDEF);
         end
         EV_ENABLE: begin
            take = (state_ff == ST_DISABLED);
            bad  = (state_ff != ST_DISABLED);
         end
         EV_DISABLE: begin
            case (state_ff)
               ST_UNDEF, ST_RUNNING, ST_SIGNALLED, ST_QUEUED: ;
               ST_DISABLED, ST_ENABLED: set_dis = 1'b1;
               default: bad = 1'b1;
            endcase
         end
         EV_SIGNAL: begin
            case (state_ff)
               ST_ENABLED: qreq = 1'b1;
               ST_DISABLED: set_dis = 1'b1;
               ST_RUNNING, ST_RUN_DIS, ST_SIGNALLED, ST_QUEUED: ;
               default: bad = 1'b1;
            endcase
         end
         EV_START: begin
            case (state_ff)
               ST_QUEUED: run = 1'b1;
               ST_QUEUED_DIS: set_dis = 1'b1;
               default: bad = 1'b1;
            endcase
         end
         EV_END: begin
            case (state_ff)
               ST_SIGNALLED: qreq = 1'b1;
               ST_RUNNING: ;
               ST_RUN_DIS: set_dis = 1'b1;
               default: bad = 1'b1;
            endcase
         end
         default: bad = 1'b1;
      endcase

      thr    = qreq && thr_ok;
      drop   = set_dis && ref_ff;
      ref_in = take ? 1'b1 : (drop ? 1'b0 : ref_ff);
      cnt_in = cnt_ff + CntWidth'(thr);

      result.new_state      = state_in;
      result.prev_state     = state_ff;
      result.queue_request  = qreq;
      result.use_threaded   = thr;
      result.run_handler    = run;
      result.ref_take       = take;
      result.ref_drop       = drop;
      result.invalid_event  = bad;
      result.threaded_total = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_UNDEF;
         ref_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else if (step) begin
         state_ff <= state_in;
         ref_ff   <= ref_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/deferred_work_state_machine_core.sv =====
// Deferred-work handler tracker.
// Events enter on the req_ channel (req_valid, req_stall, req_data) and one
// result per event leaves on the rsp_ channel (rsp_valid, rsp_stall,
// rsp_data). A transfer happens at a rising edge with valid high and stall
// low. The csr_ port writes the threaded-queueing threshold percent with
// csr_wr_en and csr_wr_data; the user must write it only while no event is
// in flight; the block itself does not enforce this. An accepted event is
// registered in the input register, processed and registered into the
// result register, which drives rsp_data. Throughput is one event per cycle
// while rsp_stall is low; the state, reference and counter update in the
// same cycle the result register loads, the loop that sets that rate.
// When rsp_stall holds a result, one more event is still taken into the
// input register; after that req_stall rises until the result is taken.
// Synchronous reset clears both pipeline valid flags, returns the handler
// to the undefined state with no reference and a zero threaded count, and
// sets the threshold to fifty percent.
module deferred_work_state_machine_core import dwsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [PctWidth-1:0] csr_wr_data
);

   logic                req_vld_ff;
   req_type             req_ff;
   logic                rsp_vld_ff;
   rsp_type             rsp_ff, rsp_in;
   logic [PctWidth-1:0] thresh_ff;
   logic                advance;
   logic                step;

   assign advance   = !rsp_vld_ff || !rsp_stall;
   assign step      = advance && req_vld_ff;
   assign req_stall = req_vld_ff && !advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   dwsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (req_ff),
      .thresh_pct (thresh_ff),
      .result     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         thresh_ff  <= ThreshReset;
      end else begin
         if (csr_wr_en) thresh_ff <= csr_wr_data;
         if (!req_stall) req_vld_ff <= req_valid;
         if (advance) rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) req_ff <= req_data;
      if (step) rsp_ff <= rsp_in;
   end

endmodule

// ===== hw/rtl/dwsm_checker.sv =====
module dwsm_checker import dwsm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic [2:0]          last_state_ff;
   logic [CntWidth-1:0] last_total_ff;

   // The last transferred result, to chain each result to the one before.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_state_ff <= ST_UNDEF;
         last_total_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         last_state_ff <= rsp_data.new_state;
         last_total_ff <= rsp_data.threaded_total;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_state_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.prev_state == last_state_ff)
      else $error("result does not start from the previous new state");

   a_total_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.threaded_total ==
                    last_total_ff + CntWidth'(rsp_data.use_threaded))
      else $error("threaded count did not follow the threaded flag");

   a_invalid_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invalid_event |->
         rsp_data.new_state == rsp_data.prev_state && !rsp_data.queue_request &&
         !rsp_data.run_handler && !rsp_data.ref_take && !rsp_data.ref_drop)
      else $error("rejected event changed state or raised an action");

   a_threaded_needs_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.use_threaded |-> rsp_data.queue_request)
      else $error("threaded flag without an insert");

endmodule

bind deferred_work_state_machine_core dwsm_checker u_dwsm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb_deferred_work_state_machine_core.sv =====
`timescale 1ns / 100ps

module tb_deferred_work_state_machine_core import dwsm_pkg::*; ();

   class handler_scoreboard;
      state_type           cur_state;
      bit                  ref_held;
      logic [CntWidth-1:0] threaded_count;
      logic [PctWidth-1:0] pct;
      rsp_type             pending_results[$];
      int unsigned         mismatches;

      function new();
         cur_state      = ST_UNDEF;
         ref_held       = 1'b0;
         threaded_count = '0;
         pct            = ThreshReset;
         mismatches     = 0;
      endfunction

      function void set_percent(logic [PctWidth-1:0] value);
         pct = value;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // The product is kept at full width, so thresholds above one hundred
      // percent are handled exactly.
      function state_type queue_insert(req_type ev, output logic threaded);
         logic [ScaleWidth-1:0] level;
         level    = (ScaleWidth'(ev.watchdog_limit) * pct) / PctScale;
         threaded = ev.watchdog_valid && (ScaleWidth'(ev.watchdog_remaining) < level);
         if (threaded) threaded_count++;
         return ev.queue_accepted ? ST_QUEUED : ST_SIGNALLED;
      endfunction

      function void note_event(req_type ev);
         rsp_type   r;
         state_type nxt;
         bit        to_disabled;
         r            = '0;
         r.prev_state = cur_state;
         nxt          = cur_state;
         to_disabled  = 1'b0;
         case (ev.func)
            EV_INIT: begin
               if (cur_state == ST_UNDEF) nxt = ST_DISABLED;
               else r.invalid_event = 1'b1;
            end
            EV_ENABLE: begin
               if (cur_state == ST_DISABLED) begin
                  nxt        = ST_ENABLED;
                  r.ref_take = 1'b1;
                  ref_held   = 1'b1;
               end else begin
                  r.invalid_event = 1'b1;
               end
            end
            EV_DISABLE: begin
               case (cur_state)
                  ST_UNDEF: ;
                  ST_DISABLED, ST_ENABLED: begin
                     nxt         = ST_DISABLED;
                     to_disabled = 1'b1;
                  end
                  ST_RUNNING, ST_SIGNALLED: nxt = ST_RUN_DIS;
                  ST_QUEUED: nxt = ST_QUEUED_DIS;
                  default: r.invalid_event = 1'b1;
               endcase
            end
            EV_SIGNAL: begin
               case (cur_state)
                  ST_ENABLED: begin
                     r.queue_request = 1'b1;
                     nxt = queue_insert(ev, r.use_threaded);
                  end
                  ST_RUNNING: nxt = ST_SIGNALLED;
                  ST_DISABLED: to_disabled = 1'b1;
                  ST_RUN_DIS, ST_SIGNALLED, ST_QUEUED: ;
                  default: r.invalid_event = 1'b1;
               endcase
            end
            EV_START: begin
               if (cur_state == ST_QUEUED) begin
                  nxt           = ST_RUNNING;
                  r.run_handler = 1'b1;
               end else if (cur_state == ST_QUEUED_DIS) begin
                  nxt         = ST_DISABLED;
                  to_disabled = 1'b1;
               end else begin
                  r.invalid_event = 1'b1;
               end
            end
            EV_END: begin
               case (cur_state)
                  ST_SIGNALLED: begin
                     r.queue_request = 1'b1;
                     nxt = queue_insert(ev, r.use_threaded);
                  end
                  ST_RUNNING: nxt = ST_ENABLED;
                  ST_RUN_DIS: begin
                     nxt         = ST_DISABLED;
                     to_disabled = 1'b1;
                  end
                  default: r.invalid_event = 1'b1;
               endcase
            end
            default: r.invalid_event = 1'b1;
         endcase
         if (to_disabled && ref_held) begin
            r.ref_drop = 1'b1;
            ref_held   = 1'b0;
         end
         cur_state        = nxt;
         r.new_state      = nxt;
         r.threaded_total = threaded_count;
         pending_results.push_back(r);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%s mismatch: expected %0h, got %0h", field, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with no event waiting: %h", got);
            return;
         end
         want = pending_results.pop_front();
         compare_field("new_state", want.new_state, got.new_state);
         compare_field("prev_state", want.prev_state, got.prev_state);
         compare_field("queue_request", want.queue_request, got.queue_request);
         compare_field("use_threaded", want.use_threaded, got.use_threaded);
         compare_field("run_handler", want.run_handler, got.run_handler);
         compare_field("ref_take", want.ref_take, got.ref_take);
         compare_field("ref_drop", want.ref_drop, got.ref_drop);
         compare_field("invalid_event", want.invalid_event, got.invalid_event);
         compare_field("threaded_total", want.threaded_total, got.threaded_total);
      endfunction
   endclass

   localparam logic [2:0] EV_UNUSED6 = 3'd6;
   localparam logic [2:0] EV_UNUSED7 = 3'd7;
   localparam int         IdleLimit  = 4000;
   localparam int         PhaseItems = 140;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_wr_en;
   logic [PctWidth-1:0] csr_wr_data;

   handler_scoreboard sb = new();
   bit                no_idle;
   bit                hold_rsp_req;
   int                idle_cycles;

   deferred_work_state_machine_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Events that move the handler or are quiet no-ops; flagged ones are excluded.
   function automatic bit event_legal(state_type s, logic [2:0] f);
      case (f)
         EV_INIT:    return s == ST_UNDEF;
         EV_ENABLE:  return s == ST_DISABLED;
         EV_DISABLE: return s != ST_RUN_DIS && s != ST_QUEUED_DIS;
         EV_SIGNAL:  return s != ST_UNDEF && s != ST_QUEUED_DIS;
         EV_START:   return s == ST_QUEUED || s == ST_QUEUED_DIS;
         EV_END:     return s == ST_SIGNALLED || s == ST_RUNNING || s == ST_RUN_DIS;
         default:    return 1'b0;
      endcase
   endfunction

   function automatic req_type make_event(logic [2:0] f, logic acc = 1'b0,
                                          logic wv = 1'b0,
                                          logic [WdWidth-1:0] rem = '0,
                                          logic [WdWidth-1:0] lim = '0);
      req_type ev;
      ev.func               = f;
      ev.queue_accepted     = acc;
      ev.watchdog_valid     = wv;
      ev.watchdog_remaining = rem;
      ev.watchdog_limit     = lim;
      return ev;
   endfunction

   // Mostly events that the current state accepts, with the remaining count
   // often placed right at the threaded-queueing boundary.
   function automatic req_type random_event(state_type s, logic [PctWidth-1:0] pct);
      req_type               ev;
      logic [ScaleWidth-1:0] level;
      ev.queue_accepted = ($urandom_range(0, 3) != 0);
      ev.watchdog_valid = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 3))
         0:       ev.watchdog_limit = '1;
         1:       ev.watchdog_limit = $urandom_range(0, 1000);
         default: ev.watchdog_limit = $urandom;
      endcase
      level = (ScaleWidth'(ev.watchdog_limit) * pct) / PctScale;
      case ($urandom_range(0, 4))
         0:       ev.watchdog_remaining = $urandom;
         1:       ev.watchdog_remaining = '1;
         2:       ev.watchdog_remaining = $urandom_range(0, 3);
         default: ev.watchdog_remaining = level[WdWidth-1:0] + $urandom_range(0, 2) - 1;
      endcase
      if ($urandom_range(0, 9) < 8) begin
         do ev.func = 3'($urandom_range(EV_INIT, EV_END));
         while (!event_legal(s, ev.func));
      end else begin
         ev.func = 3'($urandom_range(EV_INIT, EV_UNUSED7));
      end
      return ev;
   endfunction

   task automatic send_event(input req_type ev);
      int gap;
      req_data  <= ev;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_event(ev);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_events();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_percent(input logic [PctWidth-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_percent(value);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : result_side
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = pick_gap();
         if (hold_rsp_req) begin
            n            = 90;
            hold_rsp_req = 1'b0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [PctWidth-1:0] pct_plan [6];
      int p, i;
      pct_plan    = '{7'd0, 7'd100, 7'd127, 7'd1, 7'd0, ThreshReset};
      pct_plan[4] = $urandom_range(0, 127);
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      no_idle      = 1'b0;
      hold_rsp_req = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Walk every state, the quiet no-ops, the flagged events and both
      // outcomes of the insert, at the reset threshold of fifty percent.
      send_event(make_event(EV_DISABLE));
      send_event(make_event(EV_SIGNAL));
      send_event(make_event(EV_UNUSED7));
      send_event(make_event(EV_INIT));
      send_event(make_event(EV_INIT));
      send_event(make_event(EV_SIGNAL));
      send_event(make_event(EV_DISABLE));
      send_event(make_event(EV_ENABLE));
      send_event(make_event(EV_ENABLE));
      send_event(make_event(EV_SIGNAL, 1'b1, 1'b1, '0, '1));
      send_event(make_event(EV_SIGNAL));
      send_event(make_event(EV_START));
      send_event(make_event(EV_END));
      send_event(make_event(EV_SIGNAL, 1'b0, 1'b1, 32'd49, 32'd100));
      send_event(make_event(EV_END, 1'b1, 1'b0, '0, '1));
      send_event(make_event(EV_DISABLE));
      send_event(make_event(EV_SIGNAL));
      send_event(make_event(EV_START));
      send_event(make_event(EV_ENABLE));
      send_event(make_event(EV_SIGNAL, 1'b1, 1'b1, 32'd50, 32'd100));
      send_event(make_event(EV_START));
      send_event(make_event(EV_SIGNAL));
      send_event(make_event(EV_DISABLE));
      send_event(make_event(EV_SIGNAL));
      send_event(make_event(EV_END, 1'b1, 1'b1, '1, '1));
      send_event(make_event(EV_UNUSED6));
      send_event(make_event(EV_ENABLE));
      send_event(make_event(EV_DISABLE));

      for (p = 0; p < 6; p++) begin
         drain_events();
         write_percent(pct_plan[p]);
         for (i = 0; i < PhaseItems; i++) begin
            if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
            // Hold the result side long enough that the input side backs up.
            if (p == 2 && i == 40) hold_rsp_req = 1'b1;
            if (p == 3 && i == 70) drain_events();
            send_event(random_event(sb.cur_state, sb.pct));
         end
      end

      drain_events();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/dwsm_pkg.sv
hw/rtl/dwsm_ctrl.sv
hw/rtl/deferred_work_state_machine_core.sv
hw/rtl/dwsm_checker.sv
tb/sv/tb_deferred_work_state_machine_core.sv
